>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the Dalitz region test.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define DPIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

// Next-cycle implication that is also checked during reset.
`define DPIC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset rule");

`endif

>>> hw/rtl/dpic_pkg.sv
// Shared constants of the Dalitz region test: default widths, limb size, register codes.
// No dependencies.
`default_nettype none

package dpic_pkg;

    localparam int MASS_BITS_DEF = 24;
    localparam int LIMB_W        = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MOTHER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAU_1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAU_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAU_3  = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/dpic_in_if.sv
// Request channel carrying one Dalitz point (two pair masses).
// Depends on dpic_pkg (default mass width).
`default_nettype none

interface dpic_in_if #(
    parameter int MASS_BITS = dpic_pkg::MASS_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [MASS_BITS-1:0] pair_mass_two_three;
    logic [MASS_BITS-1:0] pair_mass_one_three;

    modport source (output valid, output pair_mass_two_three, output pair_mass_one_three,
                    input ready);
    modport sink   (input valid, input pair_mass_two_three, input pair_mass_one_three,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dpic_out_if.sv
// Result channel carrying the inside flag of one Dalitz point.
// No dependencies.
`default_nettype none

interface dpic_out_if ();
    logic valid;
    logic ready;
    logic inside_region;

    modport source (output valid, output inside_region, input ready);
    modport sink   (input valid, input inside_region, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dpic_mul.sv
// Pipelined signed multiplier built from limb partial products and a registered adder tree.
// Depends on dpic_pkg (limb width).
`default_nettype none

module dpic_mul #(
    parameter int A_W    = 32,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic signed [A_W-1:0]   i_a,
    input  wire logic signed [B_W-1:0]   i_b,
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic signed [A_W+B_W-1:0]    o_prod,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int LW  = dpic_pkg::LIMB_W;
    localparam int P_W = A_W + B_W;
    localparam int NA  = (A_W + LW - 1) / LW;
    localparam int NB  = (B_W + LW - 1) / LW;
    localparam int NP  = NA * NB;
    localparam int LV  = $clog2(NP);
    localparam int EAW = NA * LW;
    localparam int EBW = NB * LW;

    logic [A_W-1:0]    r_ma;
    logic [B_W-1:0]    r_mb;
    logic              r_sg0;
    logic [SIDE_W-1:0] r_sd0;
    logic [EAW-1:0]    w_ea;
    logic [EBW-1:0]    w_eb;

    logic [P_W-1:0]    r_t   [LV+1][NP];
    logic              r_sgt [LV+1];
    logic [SIDE_W-1:0] r_st  [LV+1];

    logic signed [P_W-1:0] r_p;
    logic [SIDE_W-1:0]     r_sf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
            r_mb  <= i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b);
            r_sg0 <= i_a[A_W-1] ^ i_b[B_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd0 <= '0;
        end else if (i_en) begin
            r_sd0 <= i_side;
        end
    end

    assign w_ea = EAW'(r_ma);
    assign w_eb = EBW'(r_mb);

    for (genvar gi = 0; gi < NA; gi++) begin : g_row
        for (genvar gj = 0; gj < NB; gj++) begin : g_col
            logic [2*LW-1:0] w_pp;
            assign w_pp = w_ea[gi*LW +: LW] * w_eb[gj*LW +: LW];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[0][gi*NB+gj] <= P_W'(w_pp) << (LW * (gi + gj));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgt[0] <= r_sg0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0] <= '0;
        end else if (i_en) begin
            r_st[0] <= r_sd0;
        end
    end

    for (genvar gl = 0; gl < LV; gl++) begin : g_lvl
        localparam int CL = (NP + (1 << gl) - 1) >> gl;
        for (genvar gk = 0; gk < (CL + 1) / 2; gk++) begin : g_node
            if (2 * gk + 1 < CL) begin : g_add
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_t[gl+1][gk] <= r_t[gl][2*gk] + r_t[gl][2*gk+1];
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_t[gl+1][gk] <= r_t[gl][2*gk];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sgt[gl+1] <= r_sgt[gl];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[gl+1] <= '0;
            end else if (i_en) begin
                r_st[gl+1] <= r_st[gl];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_sgt[LV] ? P_W'(-r_t[LV][0]) : r_t[LV][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf <= '0;
        end else if (i_en) begin
            r_sf <= r_st[LV];
        end
    end

    assign o_prod = r_p;
    assign o_side = r_sf;

endmodule

`default_nettype wire

>>> hw/rtl/dalitz_point_inside_check_unit.sv
// Dalitz region membership test for a three-body decay, exact integer arithmetic.
// Depends on dpic_pkg, dpic_in_if, dpic_out_if and dpic_mul.
//
// Usage:
//   Four mass registers (mother, daughters one to three) are written through the
//   plain write port i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
//   Requests arrive on i_pt, one point (m23, m13) each; every request produces exactly
//   one result on o_res, in order, with inside_region set when the point lies in the
//   allowed region, both boundaries included.
//   Throughput is one request per cycle while o_res does not stall. The datapath
//   is three multiplier stages (squares, the quadratic terms, then the two final
//   products), each a limb multiplier with a registered adder tree, separated by
//   add stages. The adder-tree depth of the wide multipliers, and so the delay from
//   an accepted request to o_res, grows with the mass width (24 bits by default).
//   Reset is synchronous and clears the mass registers and all valid bits, including
//   o_res.valid; i_pt.ready is high right after reset.
//   When o_res stalls, one more result is caught in a skid register, after which
//   i_pt.ready drops and the whole pipeline holds; nothing is lost or repeated.
`default_nettype none

module dalitz_point_inside_check_unit #(
    parameter int MASS_BITS = dpic_pkg::MASS_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dpic_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [MASS_BITS-1:0]             i_cfg_data,
    dpic_in_if.sink                               i_pt,
    dpic_out_if.source                            o_res
);

    localparam int SQ_W = MASS_BITS + 1;
    localparam int P1_W = 2 * SQ_W;
    localparam int W2   = 2 * MASS_BITS + 3;
    localparam int P2_W = 2 * W2;
    localparam int W3   = 4 * MASS_BITS + 4;
    localparam int P3_W = 2 * W3;

    logic [MASS_BITS-1:0] r_mother;
    logic [MASS_BITS-1:0] r_dau1;
    logic [MASS_BITS-1:0] r_dau2;
    logic [MASS_BITS-1:0] r_dau3;

    logic w_en;
    logic w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mother <= '0;
            r_dau1   <= '0;
            r_dau2   <= '0;
            r_dau3   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpic_pkg::REG_MOTHER: r_mother <= i_cfg_data;
                dpic_pkg::REG_DAU_1:  r_dau1   <= i_cfg_data;
                dpic_pkg::REG_DAU_2:  r_dau2   <= i_cfg_data;
                dpic_pkg::REG_DAU_3:  r_dau3   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic                 r_v0;
    logic                 r_dz0;
    logic [MASS_BITS-1:0] r_m23;
    logic [MASS_BITS-1:0] r_m13;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m23 <= i_pt.pair_mass_two_three;
            r_m13 <= i_pt.pair_mass_one_three;
            r_dz0 <= (i_pt.pair_mass_two_three == '0);
        end
    end

    // Squares of the point and of the configured masses.
    logic signed [SQ_W-1:0] w_s_m23, w_s_m13, w_s_mo, w_s_d1, w_s_d2, w_s_d3;
    logic signed [P1_W-1:0] p_d, p_s13, p_q0, p_q1, p_q2, p_q3;
    logic [1:0]             w_side1;

    assign w_s_m23 = signed'({1'b0, r_m23});
    assign w_s_m13 = signed'({1'b0, r_m13});
    assign w_s_mo  = signed'({1'b0, r_mother});
    assign w_s_d1  = signed'({1'b0, r_dau1});
    assign w_s_d2  = signed'({1'b0, r_dau2});
    assign w_s_d3  = signed'({1'b0, r_dau3});

    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(2)) u_sq_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_m23), .i_b(w_s_m23), .i_side({r_v0, r_dz0}),
        .o_prod(p_d), .o_side(w_side1)
    );
    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(1)) u_sq_s13 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_m13), .i_b(w_s_m13), .i_side(1'b0),
        .o_prod(p_s13), .o_side()
    );
    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(1)) u_sq_mo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_mo), .i_b(w_s_mo), .i_side(1'b0),
        .o_prod(p_q0), .o_side()
    );
    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(1)) u_sq_d1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_d1), .i_b(w_s_d1), .i_side(1'b0),
        .o_prod(p_q1), .o_side()
    );
    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(1)) u_sq_d2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_d2), .i_b(w_s_d2), .i_side(1'b0),
        .o_prod(p_q2), .o_side()
    );
    dpic_mul #(.A_W(SQ_W), .B_W(SQ_W), .SIDE_W(1)) u_sq_d3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_s_d3), .i_b(w_s_d3), .i_side(1'b0),
        .o_prod(p_q3), .o_side()
    );

    // First add stage: A, B and the mass-difference term, plus scaled operands.
    logic                 r_v1;
    logic                 r_dz1;
    logic signed [W2-1:0] r_a, r_b, r_c, r_dd, r_d2, r_f1, r_f3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_dz1 <= 1'b0;
        end else if (w_en) begin
            r_v1  <= w_side1[1];
            r_dz1 <= w_side1[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a  <= W2'(p_d) - W2'(p_q2) + W2'(p_q3);
            r_b  <= W2'(p_q0) - W2'(p_d) - W2'(p_q1);
            r_c  <= W2'(p_s13) - W2'(p_q1) - W2'(p_q3);
            r_dd <= W2'(p_d);
            r_d2 <= W2'(p_d) <<< 1;
            r_f1 <= W2'(p_q1) <<< 2;
            r_f3 <= W2'(p_q3) <<< 2;
        end
    end

    // Quadratic terms.
    logic signed [P2_W-1:0] p_aa, p_f3d, p_bb, p_f1d, p_d2c, p_ab;
    logic [1:0]             w_side2;

    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(2)) u_m_aa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_a), .i_b(r_a), .i_side({r_v1, r_dz1}),
        .o_prod(p_aa), .o_side(w_side2)
    );
    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(1)) u_m_f3d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_f3), .i_b(r_dd), .i_side(1'b0),
        .o_prod(p_f3d), .o_side()
    );
    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(1)) u_m_bb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_b), .i_b(r_b), .i_side(1'b0),
        .o_prod(p_bb), .o_side()
    );
    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(1)) u_m_f1d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_f1), .i_b(r_dd), .i_side(1'b0),
        .o_prod(p_f1d), .o_side()
    );
    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(1)) u_m_d2c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_d2), .i_b(r_c), .i_side(1'b0),
        .o_prod(p_d2c), .o_side()
    );
    dpic_mul #(.A_W(W2), .B_W(W2), .SIDE_W(1)) u_m_ab (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_a), .i_b(r_b), .i_side(1'b0),
        .o_prod(p_ab), .o_side()
    );

    // Second add stage: the two radicands and the cross term.
    logic                 r_v2;
    logic                 r_dz2;
    logic signed [W3-1:0] r_x, r_y, r_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_dz2 <= 1'b0;
        end else if (w_en) begin
            r_v2  <= w_side2[1];
            r_dz2 <= w_side2[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= W3'(p_aa - p_f3d);
            r_y <= W3'(p_bb - p_f1d);
            r_l <= W3'(p_d2c - p_ab);
        end
    end

    // Final products.
    logic signed [P3_W-1:0] p_ll, p_xy;
    logic [3:0]             w_side3;

    dpic_mul #(.A_W(W3), .B_W(W3), .SIDE_W(4)) u_m_ll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_l), .i_b(r_l), .i_side({r_v2, r_dz2, r_x[W3-1], r_y[W3-1]}),
        .o_prod(p_ll), .o_side(w_side3)
    );
    dpic_mul #(.A_W(W3), .B_W(W3), .SIDE_W(1)) u_m_xy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(r_x), .i_b(r_y), .i_side(1'b0),
        .o_prod(p_xy), .o_side()
    );

    // Compare stage.
    logic r_v3;
    logic r_in3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= w_side3[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in3 <= !w_side3[2] && !w_side3[1] && !w_side3[0] && (p_ll <= p_xy);
        end
    end

    // Output register with a skid stage.
    logic r_out_v;
    logic r_out_flag;
    logic r_skid_v;
    logic r_skid_flag;

    assign w_en       = !r_skid_v;
    assign w_out_free = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_v <= r_skid_v || r_v3;
            end
            if (r_skid_v && w_out_free) begin
                r_skid_v <= 1'b0;
            end else if (!r_skid_v && r_v3 && !w_out_free) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_flag <= r_skid_v ? r_skid_flag : r_in3;
        end
        if (!r_skid_v) begin
            r_skid_flag <= r_in3;
        end
    end

    assign i_pt.ready          = w_en;
    assign o_res.valid         = r_out_v;
    assign o_res.inside_region = r_out_flag;

endmodule

`default_nettype wire

>>> hw/rtl/dpic_checker.sv
// Port-level checks of the Dalitz region test and the bind that attaches them.
// Depends on assert_macros.svh and dalitz_point_inside_check_unit.
`default_nettype none

`include "assert_macros.svh"

module dpic_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_flag
);

    logic w_stall;

    assign w_stall = i_out_valid && !i_out_ready;

    // A stalled result stays valid and unchanged.
    `DPIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(i_out_flag))

    // The request side only blocks while a result is waiting.
    `DPIC_ASSERT_NOW(a_block_has_result, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // Blocking starts only after a stalled result.
    `DPIC_ASSERT_NOW(a_block_after_stall, i_clk, i_rst_n, $fell(i_in_ready), $past(w_stall))

    // Reset leaves the block empty and open for requests.
    `DPIC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind dalitz_point_inside_check_unit dpic_checker u_dpic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_flag  (o_res.inside_region)
);

`default_nettype wire

>>> test/dalitz_point_inside_check_unit_tb.sv
// Self-checking testbench for dalitz_point_inside_check_unit: directed table, then random phases.
// Depends on dpic_pkg, dpic_in_if, dpic_out_if and the unit itself; exact wide-integer predictor.
`default_nettype none

module dalitz_point_inside_check_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MB = dpic_pkg::MASS_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 175;

    typedef logic [MB-1:0] t_mass;
    typedef logic signed [263:0] t_wide;
    typedef logic [dpic_pkg::CFG_IDX_W-1:0] t_reg_idx;

    localparam t_mass MAX_MASS = '1;

    typedef enum logic {ROW_POINT, ROW_WRITE} t_row_kind;
    typedef enum logic [1:0] {FLAG_OUT, FLAG_IN, FLAG_MODEL} t_flag_src;

    typedef struct packed {
        t_row_kind kind;
        t_reg_idx  idx;
        t_mass     a;
        t_mass     b;
        t_flag_src flag;
    } t_row;

    localparam int ROWS = 29;
    localparam t_row DIRECTED [ROWS] = '{
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 0, 0, FLAG_OUT},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 0, MAX_MASS, FLAG_OUT},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, MAX_MASS, 0, FLAG_IN},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, MAX_MASS, MAX_MASS, FLAG_OUT},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 1, 0, FLAG_IN},
        '{ROW_WRITE, dpic_pkg::REG_MOTHER, 10, 0, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 6, 8, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 6, 0, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 6, 9, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 11, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_MOTHER, 20, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_1, 5, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_2, 3, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_3, 4, 0, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 7, 15, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 6, 10, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 15, 12, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 10, 10, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 0, 5, FLAG_OUT},
        '{ROW_WRITE, dpic_pkg::REG_MOTHER, MAX_MASS, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_1, MAX_MASS, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_2, MAX_MASS, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_3, MAX_MASS, 0, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, MAX_MASS, MAX_MASS, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, 1, 1, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_1, 1, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_2, 1, 0, FLAG_MODEL},
        '{ROW_WRITE, dpic_pkg::REG_DAU_3, 1, 0, FLAG_MODEL},
        '{ROW_POINT, dpic_pkg::REG_MOTHER, MAX_MASS, 1, FLAG_MODEL}
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_reg_idx i_cfg_idx;
    t_mass    i_cfg_data;

    dpic_in_if #(.MASS_BITS(MB)) pt_if ();
    dpic_out_if res_if ();

    dalitz_point_inside_check_unit #(.MASS_BITS(MB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    t_mass mass_mother;
    t_mass mass_d1;
    t_mass mass_d2;
    t_mass mass_d3;

    logic inside_flags_due [$];
    int   mismatch_count;
    int   quiet_cycles;
    logic calm;

    function automatic t_wide square_of(t_mass v);
        t_wide w;
        w = t_wide'(v);
        return w * w;
    endfunction

    function automatic logic region_contains(t_mass m23, t_mass m13);
        t_wide d, a, b, x, y, l, s1, s3;
        d = square_of(m23);
        if (d == 0) begin
            return 1'b0;
        end
        s1 = square_of(mass_d1);
        s3 = square_of(mass_d3);
        a = d - square_of(mass_d2) + s3;
        b = square_of(mass_mother) - d - s1;
        x = a * a - 4 * s3 * d;
        y = b * b - 4 * s1 * d;
        if (x < 0 || y < 0) begin
            return 1'b0;
        end
        l = 2 * d * (square_of(m13) - s1 - s3) - a * b;
        return (l * l <= x * y);
    endfunction

    function automatic int unsigned pick_delay();
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end else begin
            return $urandom_range(40, 4);
        end
    endfunction

    task automatic send_point(t_mass m23, t_mass m13, t_flag_src flag);
        int unsigned gap;
        gap = pick_delay();
        if (gap > 0) begin
            @(negedge i_clk);
            pt_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pt_if.valid               <= 1'b1;
        pt_if.pair_mass_two_three <= m23;
        pt_if.pair_mass_one_three <= m13;
        do @(posedge i_clk); while (!pt_if.ready);
        if (flag == FLAG_MODEL) begin
            inside_flags_due.push_back(region_contains(m23, m13));
        end else begin
            inside_flags_due.push_back(flag == FLAG_IN);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        pt_if.valid <= 1'b0;
        while (inside_flags_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, t_mass value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dpic_pkg::REG_MOTHER: mass_mother = value;
            dpic_pkg::REG_DAU_1:  mass_d1 = value;
            dpic_pkg::REG_DAU_2:  mass_d2 = value;
            dpic_pkg::REG_DAU_3:  mass_d3 = value;
            default: ;
        endcase
    endtask

    task automatic configure(int ph);
        t_mass m, d1, d2, d3;
        case (ph % 4)
            0: begin
                m  = t_mass'($urandom_range(MAX_MASS, 1000));
                d1 = t_mass'($urandom_range(m / 3));
                d2 = t_mass'($urandom_range(m / 3));
                d3 = t_mass'($urandom_range(m / 3));
            end
            1: begin
                m  = t_mass'($urandom_range(300, 8));
                d1 = t_mass'($urandom_range(m / 3));
                d2 = t_mass'($urandom_range(m / 3));
                d3 = t_mass'($urandom_range(m / 3));
            end
            2: begin
                m  = MAX_MASS;
                d1 = (ph > 3 && $urandom_range(1)) ? MAX_MASS : '0;
                d2 = (ph > 3 && $urandom_range(1)) ? MAX_MASS : '0;
                d3 = (ph > 3 && $urandom_range(1)) ? MAX_MASS : '0;
            end
            default: begin
                m  = t_mass'($urandom);
                d1 = t_mass'($urandom);
                d2 = t_mass'($urandom);
                d3 = t_mass'($urandom);
            end
        endcase
        write_reg(dpic_pkg::REG_MOTHER, m);
        write_reg(dpic_pkg::REG_DAU_1, d1);
        write_reg(dpic_pkg::REG_DAU_2, d2);
        write_reg(dpic_pkg::REG_DAU_3, d3);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int unsigned stall, run;
        res_if.ready = 1'b0;
        forever begin
            run = calm ? 8 : $urandom_range(12, 1);
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            stall = pick_delay();
            if (stall > 0) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (inside_flags_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: inside_region=%0b", res_if.inside_region);
                end
            end else if (res_if.inside_region !== inside_flags_due[0]) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch on inside_region: expected %0b, got %0b",
                             inside_flags_due[0], res_if.inside_region);
                end
                void'(inside_flags_due.pop_front());
            end else begin
                void'(inside_flags_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned lo23, hi23, lo13, hi13, daughters, r;
        t_mass m23, m13;
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_idx                 = dpic_pkg::REG_MOTHER;
        i_cfg_data                = '0;
        pt_if.valid               = 1'b0;
        pt_if.pair_mass_two_three = '0;
        pt_if.pair_mass_one_three = '0;
        mass_mother               = '0;
        mass_d1                   = '0;
        mass_d2                   = '0;
        mass_d3                   = '0;
        mismatch_count            = 0;
        quiet_cycles              = 0;
        calm                      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                settle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].a);
            end else begin
                send_point(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].flag);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            configure(ph);
            calm = ($urandom_range(3) == 0);
            daughters = 32'(mass_d1) + 32'(mass_d2) + 32'(mass_d3);
            lo23 = 32'(mass_d2) + 32'(mass_d3);
            hi23 = 32'(mass_mother) - 32'(mass_d1);
            lo13 = 32'(mass_d1) + 32'(mass_d3);
            hi13 = 32'(mass_mother) - 32'(mass_d2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                m23 = t_mass'($urandom);
                m13 = t_mass'($urandom);
                if (32'(mass_mother) >= daughters && r < 80) begin
                    m13 = t_mass'($urandom_range(hi13, lo13));
                    if (r < 70) begin
                        m23 = t_mass'($urandom_range(hi23, lo23));
                    end else if (r < 75) begin
                        m23 = '0;
                    end else begin
                        m23 = t_mass'($urandom_range(1) ? lo23 : hi23);
                    end
                end else if (r < 85) begin
                    m23 = '0;
                end
                send_point(m23, m13, FLAG_MODEL);
            end
            calm = 1'b0;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
